/* sv/rpn_pkg.sv */
`timescale 1ns / 1ps
// Shared constants for the RPN stack calculator: stack size, field widths,
// command codes and status codes. Depends on nothing.
package rpn_pkg;

  localparam int STACK_DEPTH = 16;
  localparam int DATA_W      = 32;
  localparam int CMD_W       = 3;
  localparam int STATUS_W    = 3;
  localparam int DEPTH_W     = 5;
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int ADDR_W      = $clog2(STACK_DEPTH);
  localparam int ITER_W      = $clog2(DATA_W);

  typedef logic [CMD_W-1:0]    cmd_t;
  typedef logic [STATUS_W-1:0] status_t;
  typedef logic [DATA_W-1:0]   data_t;

  localparam cmd_t CMD_PUSH = 3'd0;
  localparam cmd_t CMD_ADD  = 3'd1;
  localparam cmd_t CMD_SUB  = 3'd2;
  localparam cmd_t CMD_MUL  = 3'd3;
  localparam cmd_t CMD_DIV  = 3'd4;

  localparam status_t ST_OK      = 3'd0;
  localparam status_t ST_EMPTY   = 3'd1;
  localparam status_t ST_ONE     = 3'd2;
  localparam status_t ST_FULL    = 3'd3;
  localparam status_t ST_DIVZERO = 3'd4;

endpackage

/* sv/rpn_stack_calculator_unit.sv */
`timescale 1ns / 1ps
// RPN stack calculator top level: operand stack memory, cached top entry,
// arithmetic and an iterative divider. Depends on rpn_pkg.
//
// Usage: a command transfer happens at a rising edge with start high and
// busy low; in_command selects push, add, subtract, multiply or divide and
// in_value is the number to push. Every command yields exactly one result,
// shown on out_status, out_top_value and out_depth for one cycle while
// out_valid is high. The receiver cannot stall, so each result must be
// taken in the cycle it is shown.
// A push, any error and an unknown command give a result registered at
// the transfer; add, subtract and multiply pass through S_READ and S_WB,
// and divide through S_READ, the 32 steps of the shift-subtract divider in
// S_DIV, and S_WB. S_READ waits on the registered read of the deeper
// operand from the stack memory. busy is high from the transfer until the
// result is shown, and a new command may be transferred in the cycle its
// predecessor's result is shown.
// Reset empties the stack; stack memory contents are not cleared.
module rpn_stack_calculator_unit (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  logic [rpn_pkg::CMD_W-1:0]       in_command,
  input  logic signed [rpn_pkg::DATA_W-1:0] in_value,
  output logic                            out_valid,
  output logic [rpn_pkg::STATUS_W-1:0]    out_status,
  output logic signed [rpn_pkg::DATA_W-1:0] out_top_value,
  output logic [rpn_pkg::DEPTH_W-1:0]     out_depth
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_READ = 3'd1;
  localparam logic [2:0] S_DIV  = 3'd2;
  localparam logic [2:0] S_WB   = 3'd3;

  localparam int CW = rpn_pkg::CNT_W;
  localparam int AW = rpn_pkg::ADDR_W;
  localparam int DW = rpn_pkg::DATA_W;
  localparam int IW = rpn_pkg::ITER_W;

  rpn_pkg::data_t mem [rpn_pkg::STACK_DEPTH];
  rpn_pkg::data_t rd_r;

  logic [2:0]       state_r, state_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  rpn_pkg::cmd_t    cmd_r, cmd_nxt;
  rpn_pkg::data_t   top_r, top_nxt;
  rpn_pkg::data_t   res_r, res_nxt;
  rpn_pkg::data_t   rem_r, rem_nxt;
  rpn_pkg::data_t   dvs_r, dvs_nxt;
  logic             neg_r, neg_nxt;
  logic [IW-1:0]    iter_r, iter_nxt;
  logic             out_valid_r, out_valid_nxt;
  rpn_pkg::status_t out_status_r, out_status_nxt;
  rpn_pkg::data_t   out_top_r, out_top_nxt;
  logic [CW-1:0]    out_cnt_r, out_cnt_nxt;

  logic             mem_we, mem_re;
  logic [AW-1:0]    mem_waddr, mem_raddr;
  rpn_pkg::data_t   mem_wdata;
  logic [CW-1:0]    cnt_m2;
  logic [DW:0]      rem_sh;
  logic             ge;
  rpn_pkg::data_t   result;

  assign cnt_m2 = count_r - CW'(2);
  assign rem_sh = {rem_r, res_r[DW-1]};
  assign ge     = rem_sh >= {1'b0, dvs_r};
  assign result = ((cmd_r == rpn_pkg::CMD_DIV) && neg_r) ? (0 - res_r) : res_r;

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    cmd_nxt        = cmd_r;
    top_nxt        = top_r;
    res_nxt        = res_r;
    rem_nxt        = rem_r;
    dvs_nxt        = dvs_r;
    neg_nxt        = neg_r;
    iter_nxt       = iter_r;
    out_valid_nxt  = 1'b0;
    out_status_nxt = out_status_r;
    out_top_nxt    = out_top_r;
    out_cnt_nxt    = out_cnt_r;
    mem_we         = 1'b0;
    mem_re         = 1'b0;
    mem_waddr      = count_r[AW-1:0];
    mem_raddr      = cnt_m2[AW-1:0];
    mem_wdata      = res_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd_nxt        = in_command;
          out_valid_nxt  = 1'b1;
          out_status_nxt = rpn_pkg::ST_OK;
          out_cnt_nxt    = count_r;
          out_top_nxt    = (count_r == '0) ? '0 : top_r;
          if (in_command == rpn_pkg::CMD_PUSH) begin
            if (count_r == CW'(rpn_pkg::STACK_DEPTH)) begin
              out_status_nxt = rpn_pkg::ST_FULL;
            end else begin
              mem_we      = 1'b1;
              mem_waddr   = count_r[AW-1:0];
              mem_wdata   = in_value;
              top_nxt     = in_value;
              count_nxt   = count_r + CW'(1);
              out_cnt_nxt = count_r + CW'(1);
              out_top_nxt = in_value;
            end
          end else if (in_command == rpn_pkg::CMD_ADD || in_command == rpn_pkg::CMD_SUB ||
                       in_command == rpn_pkg::CMD_MUL || in_command == rpn_pkg::CMD_DIV) begin
            if (count_r == '0) begin
              out_status_nxt = rpn_pkg::ST_EMPTY;
            end else if (count_r == CW'(1)) begin
              out_status_nxt = rpn_pkg::ST_ONE;
            end else if (in_command == rpn_pkg::CMD_DIV && top_r == '0) begin
              out_status_nxt = rpn_pkg::ST_DIVZERO;
            end else begin
              out_valid_nxt = 1'b0;
              mem_re        = 1'b1;
              state_nxt     = S_READ;
            end
          end
        end
      end
      S_READ: begin
        state_nxt = S_WB;
        unique case (cmd_r)
          rpn_pkg::CMD_ADD: res_nxt = rd_r + top_r;
          rpn_pkg::CMD_SUB: res_nxt = rd_r - top_r;
          rpn_pkg::CMD_MUL: res_nxt = rd_r * top_r;
          default: begin
            neg_nxt   = rd_r[DW-1] ^ top_r[DW-1];
            res_nxt   = rd_r[DW-1] ? (0 - rd_r) : rd_r;
            dvs_nxt   = top_r[DW-1] ? (0 - top_r) : top_r;
            rem_nxt   = '0;
            iter_nxt  = '0;
            state_nxt = S_DIV;
          end
        endcase
      end
      S_DIV: begin
        rem_nxt  = ge ? DW'(rem_sh - {1'b0, dvs_r}) : rem_sh[DW-1:0];
        res_nxt  = {res_r[DW-2:0], ge};
        iter_nxt = iter_r + IW'(1);
        if (iter_r == IW'(DW - 1)) begin
          state_nxt = S_WB;
        end
      end
      S_WB: begin
        mem_we         = 1'b1;
        mem_waddr      = cnt_m2[AW-1:0];
        mem_wdata      = result;
        top_nxt        = result;
        count_nxt      = count_r - CW'(1);
        out_valid_nxt  = 1'b1;
        out_status_nxt = rpn_pkg::ST_OK;
        out_top_nxt    = result;
        out_cnt_nxt    = count_r - CW'(1);
        state_nxt      = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_r <= mem[mem_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r        <= cmd_nxt;
    top_r        <= top_nxt;
    res_r        <= res_nxt;
    rem_r        <= rem_nxt;
    dvs_r        <= dvs_nxt;
    neg_r        <= neg_nxt;
    iter_r       <= iter_nxt;
    out_status_r <= out_status_nxt;
    out_top_r    <= out_top_nxt;
    out_cnt_r    <= out_cnt_nxt;
  end

  assign busy          = state_r != S_IDLE;
  assign out_valid     = out_valid_r;
  assign out_status    = out_status_r;
  assign out_top_value = out_top_r;
  assign out_depth     = rpn_pkg::DEPTH_W'(out_cnt_r);

endmodule

/* sv/rpn_checker.sv */
`timescale 1ns / 1ps
// Port-level checker for the RPN stack calculator, bound to the top level.
// Depends on rpn_pkg and rpn_stack_calculator_unit.
module rpn_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              start,
  input logic                              busy,
  input logic                              out_valid,
  input logic [rpn_pkg::STATUS_W-1:0]      out_status,
  input logic signed [rpn_pkg::DATA_W-1:0] out_top_value,
  input logic [rpn_pkg::DEPTH_W-1:0]       out_depth
);

  a_transfer_progress: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (out_valid || busy))
    else $error("transfer produced neither a result nor a busy phase");

  a_result_has_cause: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ($past(start && !busy) || $past(busy)))
    else $error("result without a preceding command transfer");

  a_result_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result shown while still busy");

  a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == rpn_pkg::ST_EMPTY) |->
      (out_depth == '0 && out_top_value == '0))
    else $error("empty-stack status with nonzero depth or top");

  a_one_operand: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == rpn_pkg::ST_ONE) |-> (out_depth == 5'd1))
    else $error("single-operand status with depth other than one");

endmodule

bind rpn_stack_calculator_unit rpn_checker u_rpn_checker (.*);

/* tb/sv/testbench.sv */
`timescale 1ns / 1ps
// Self-checking testbench for rpn_stack_calculator_unit: directed stack edge cases, then
// random commands checked against an in-bench stack predictor. Depends on rpn_pkg and the DUT.
module testbench;
  import rpn_pkg::*;

  localparam cmd_t CMD_UNUSED_LO = 3'd5;
  localparam cmd_t CMD_UNUSED_HI = 3'd7;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 40;
  localparam int RANDOM_ITEMS = 670;

  typedef struct packed {
    status_t             status;
    data_t               top;
    logic [DEPTH_W-1:0]  depth;
  } calc_result_t;

  logic clk = 1'b0;
  logic rst_n;
  logic start;
  logic busy;
  logic [CMD_W-1:0] in_command;
  logic signed [DATA_W-1:0] in_value;
  logic out_valid;
  logic [STATUS_W-1:0] out_status;
  logic signed [DATA_W-1:0] out_top_value;
  logic [DEPTH_W-1:0] out_depth;

  data_t stack_mem [STACK_DEPTH];
  int unsigned stack_cnt;
  calc_result_t expected_results [$];
  int send_idle_pct;
  int fail_count;
  int commands_sent;
  int results_checked;
  int status_seen [8];
  int idle_cycles;

  rpn_stack_calculator_unit u_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_command    (in_command),
    .in_value      (in_value),
    .out_valid     (out_valid),
    .out_status    (out_status),
    .out_top_value (out_top_value),
    .out_depth     (out_depth)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic calc_result_t calc_predict(cmd_t cmd, data_t val);
    calc_result_t r;
    data_t lhs;
    data_t rhs;
    data_t res;
    data_t mag_l;
    data_t mag_r;
    data_t quo;
    r.status = ST_OK;
    res = '0;
    case (cmd)
      CMD_PUSH: begin
        if (stack_cnt >= STACK_DEPTH) begin
          r.status = ST_FULL;
        end else begin
          stack_mem[stack_cnt] = val;
          stack_cnt++;
        end
      end
      CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV: begin
        if (stack_cnt == 0) begin
          r.status = ST_EMPTY;
        end else if (stack_cnt == 1) begin
          r.status = ST_ONE;
        end else begin
          rhs = stack_mem[stack_cnt - 1];
          lhs = stack_mem[stack_cnt - 2];
          case (cmd)
            CMD_ADD: res = lhs + rhs;
            CMD_SUB: res = lhs - rhs;
            CMD_MUL: res = lhs * rhs;
            default: begin
              if (rhs == '0) begin
                r.status = ST_DIVZERO;
              end else begin
                // Divide magnitudes and restore the sign, so the quotient truncates
                // toward zero and the most negative value over minus one wraps.
                mag_l = lhs[DATA_W-1] ? -lhs : lhs;
                mag_r = rhs[DATA_W-1] ? -rhs : rhs;
                quo = mag_l / mag_r;
                res = (lhs[DATA_W-1] ^ rhs[DATA_W-1]) ? -quo : quo;
              end
            end
          endcase
          if (r.status == ST_OK) begin
            stack_cnt--;
            stack_mem[stack_cnt - 1] = res;
          end
        end
      end
      default: ;
    endcase
    r.top = (stack_cnt != 0) ? stack_mem[stack_cnt - 1] : '0;
    r.depth = stack_cnt[DEPTH_W-1:0];
    return r;
  endfunction

  task automatic send_command(cmd_t cmd, data_t val);
    calc_result_t r;
    if ($urandom_range(99) < send_idle_pct) begin
      start <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    start <= 1'b1;
    in_command <= cmd;
    in_value <= val;
    @(posedge clk);
    while (busy) @(posedge clk);
    r = calc_predict(cmd, val);
    expected_results.push_back(r);
    status_seen[r.status]++;
    commands_sent++;
  endtask

  always @(posedge clk) begin
    calc_result_t exp_r;
    if (rst_n && out_valid) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual status %0d top %0d depth %0d",
                 $time, out_status, out_top_value, out_depth);
        fail_count++;
      end else begin
        exp_r = expected_results.pop_front();
        results_checked++;
        if (out_status !== exp_r.status) begin
          $display("%0t: status mismatch: expected %0d, actual %0d",
                   $time, exp_r.status, out_status);
          fail_count++;
        end
        if (out_top_value !== exp_r.top) begin
          $display("%0t: top_value mismatch: expected %0d, actual %0d",
                   $time, $signed(exp_r.top), out_top_value);
          fail_count++;
        end
        if (out_depth !== exp_r.depth) begin
          $display("%0t: depth mismatch: expected %0d, actual %0d",
                   $time, exp_r.depth, out_depth);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: watchdog expired with %0d results outstanding",
                 $time, expected_results.size());
        $display("Mismatches found");
        $finish;
      end
    end
  end

  task automatic test_empty_stack();
    send_command(CMD_ADD, $urandom());
    send_command(CMD_SUB, $urandom());
    send_command(CMD_MUL, $urandom());
    send_command(CMD_DIV, $urandom());
  endtask

  task automatic test_unknown_command();
    send_command(CMD_UNUSED_HI, 32'hFFFF_FFFF);
  endtask

  task automatic test_single_operand();
    send_command(CMD_PUSH, 32'h7FFF_FFFF);
    send_command(CMD_MUL, '0);
  endtask

  task automatic test_overflow_wrap();
    send_command(CMD_PUSH, 32'd1);
    send_command(CMD_ADD, '0);
    send_command(CMD_PUSH, 32'hFFFF_FFFF);
    send_command(CMD_DIV, '0);
    send_command(CMD_PUSH, 32'd1);
    send_command(CMD_SUB, '0);
  endtask

  task automatic test_full_stack();
    data_t val;
    while (stack_cnt < STACK_DEPTH) begin
      if (stack_cnt == STACK_DEPTH - 1) val = '0;
      else if (stack_cnt[0]) val = 32'h8000_0000;
      else val = $urandom();
      send_command(CMD_PUSH, val);
    end
    send_command(CMD_PUSH, 32'h1234_5678);
    send_command(CMD_DIV, '0);
  endtask

  task automatic test_random_traffic(int idle_pct, int n_items);
    cmd_t cmd;
    data_t val;
    int push_pct;
    send_idle_pct = idle_pct;
    repeat (n_items) begin
      push_pct = (stack_cnt < 2) ? 75 : (stack_cnt >= STACK_DEPTH - 1) ? 35 : 50;
      if ($urandom_range(99) < 3) begin
        cmd = cmd_t'($urandom_range(CMD_UNUSED_HI, CMD_UNUSED_LO));
      end else if ($urandom_range(99) < push_pct) begin
        cmd = CMD_PUSH;
      end else begin
        cmd = cmd_t'($urandom_range(CMD_DIV, CMD_ADD));
      end
      case ($urandom_range(7))
        0: val = 32'h8000_0000;
        1: val = 32'h7FFF_FFFF;
        2: val = '0;
        3: val = '1;
        4, 5: val = data_t'($urandom_range(16)) - 32'd8;
        default: val = $urandom();
      endcase
      send_command(cmd, val);
    end
  endtask

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    in_command = CMD_PUSH;
    in_value = '0;
    stack_cnt = 0;
    fail_count = 0;
    commands_sent = 0;
    results_checked = 0;
    idle_cycles = 0;
    send_idle_pct = 17;
    foreach (status_seen[i]) status_seen[i] = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_stack();
    test_unknown_command();
    test_single_operand();
    test_overflow_wrap();
    test_full_stack();
    test_random_traffic(17, RANDOM_ITEMS);
    test_random_traffic(79, RANDOM_ITEMS);
    test_random_traffic(0, RANDOM_ITEMS);
    start <= 1'b0;

    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Run covered %0d commands and %0d checked results.",
             commands_sent, results_checked);
    $display("Outcomes: ok %0d, empty %0d, one operand %0d, full %0d, divide by zero %0d.",
             status_seen[ST_OK], status_seen[ST_EMPTY], status_seen[ST_ONE],
             status_seen[ST_FULL], status_seen[ST_DIVZERO]);
    if (fail_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
